FILE: rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Request structs, operation and status codes, sequencer state type.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int Width    = 32;
    localparam int MagW     = 64;
    localparam int GcdCntW  = 7;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               a_less_b;
        logic               a_equal_b;
        logic [1:0]         status;
    } out_req_t;

    // gcd unit handshake
    typedef struct packed {
        logic            start;
        logic [MagW-1:0] x;
        logic [MagW-1:0] y;
    } gcd_cmd_t;

    typedef struct packed {
        logic            done;
        logic [MagW-1:0] g;
    } gcd_rsp_t;

    // divider handshake
    typedef struct packed {
        logic            start;
        logic [MagW-1:0] n;
        logic [MagW-1:0] d;
    } div_cmd_t;

    typedef struct packed {
        logic            done;
        logic [MagW-1:0] q;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NORM_A,
        S_NORM_A_WAIT,
        S_DIV_AN,
        S_DIV_AD,
        S_NORM_B,
        S_NORM_B_WAIT,
        S_DIV_BN,
        S_DIV_BD,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_COMBINE,
        S_RES_GCD,
        S_RES_WAIT,
        S_DIV_RN,
        S_DIV_RD,
        S_CHECK,
        S_OUT
    } state_t;

endpackage : rau_pkg
`default_nettype wire

FILE: rtl/rau_gcd.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rau_gcd: binary gcd of two 64-bit magnitudes
// One subtract and shift step per cycle; both inputs must be nonzero.
// ---------------------------------------------------------------------------
module rau_gcd (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rau_pkg::gcd_cmd_t cmd,
    output rau_pkg::gcd_rsp_t      rsp
);
    import rau_pkg::*;

    logic [MagW-1:0]    x_reg, x_next, y_reg, y_next;
    logic [GcdCntW-1:0] k_reg, k_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic [MagW-1:0]    diff;

    assign diff = (x_reg > y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            x_next    = cmd.x;
            y_next    = cmd.y;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (x_reg == y_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!x_reg[0] && !y_reg[0]) begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!x_reg[0]) begin
                x_next = x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_next = y_reg >> 1;
            end else begin
                // both odd: keep the smaller, halve the difference
                if (x_reg > y_reg) x_next = diff >> 1;
                else               y_next = diff >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
    end

    assign rsp = '{done: done_reg, g: x_reg << k_reg};

    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("gcd done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !cmd.start) |-> (x_reg != '0 && y_reg != '0))
        else $error("gcd operand reached zero");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> $past(busy_reg))
        else $error("gcd done without work");

endmodule : rau_gcd
`default_nettype wire

FILE: rtl/rau_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rau_div: restoring divider, 64 by 64 bits
// One quotient bit per cycle; the divisor must be nonzero.
// ---------------------------------------------------------------------------
module rau_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rau_pkg::div_cmd_t cmd,
    output rau_pkg::div_rsp_t      rsp
);
    import rau_pkg::*;

    logic [MagW-1:0]    q_reg, q_next, d_reg, d_next;
    logic [MagW:0]      r_reg, r_next, trial;
    logic [GcdCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;

    assign trial = {r_reg[MagW-1:0], q_reg[MagW-1]} - {1'b0, d_reg};

    always_comb begin
        q_next    = q_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            q_next    = cmd.n;
            d_next    = cmd.d;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[MagW]) begin
                r_next = {r_reg[MagW-1:0], q_reg[MagW-1]};
                q_next = {q_reg[MagW-2:0], 1'b0};
            end else begin
                r_next = trial;
                q_next = {q_reg[MagW-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == GcdCntW'(MagW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign rsp = '{done: done_reg, q: q_reg};

    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !cmd.start) |-> (r_reg < {1'b0, d_reg}))
        else $error("partial remainder not below divisor");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> $past(busy_reg))
        else $error("divider done without work");

endmodule : rau_div
`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply or divide two fractions
// One request at a time; normalizes both operands, computes, reduces.
// ---------------------------------------------------------------------------
// Each request uses up to three binary gcd runs (one subtract or shift step
// per cycle) and six restoring divisions: one gcd and two divisions each to
// reduce the first operand, the second operand and the result. A zero numerator
// skips its reduction, and a nonzero numerator over a zero denominator ends the
// request early. s_ready is low from accept until the result is taken. Cross
// products go through one 32x32 multiplier, one product in each of S_MUL1 to
// S_MUL4.
module rational_arithmetic_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire rau_pkg::in_req_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output rau_pkg::out_req_t     m_data
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]      op_reg;
    logic [31:0]     bn_raw_reg, bd_raw_reg;
    logic            an_reg, bn_reg, rn_reg;
    logic [MagW-1:0] am_reg, ad_reg, bm_reg, bd_reg;
    logic [MagW-1:0] rm_reg, rd_reg, g_reg;
    logic [MagW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [1:0]      status_reg;
    logic            less_reg, equal_reg;
    out_req_t        out_reg;

    gcd_cmd_t gcmd;
    gcd_rsp_t grsp;
    div_cmd_t dcmd;
    div_rsp_t drsp;

    rau_gcd u_gcd (.aclk(aclk), .aresetn(aresetn), .cmd(gcmd), .rsp(grsp));
    rau_div u_div (.aclk(aclk), .aresetn(aresetn), .cmd(dcmd), .rsp(drsp));

    function automatic logic [MagW-1:0] mag_of(input logic [31:0] v);
        return v[31] ? (MagW'(33'h1_0000_0000) - MagW'(v)) : MagW'(v);
    endfunction

    // shared multiplier; operand magnitudes after reduction stay at or below 2^31
    logic [31:0]     mx, my;
    logic [MagW-1:0] mprod;
    assign mprod = MagW'(mx) * MagW'(my);

    always_comb begin
        mx = am_reg[31:0];
        my = bd_reg[31:0];
        unique case (state_reg)
            S_MUL1: begin mx = am_reg[31:0]; my = bd_reg[31:0]; end
            S_MUL2: begin mx = bm_reg[31:0]; my = ad_reg[31:0]; end
            S_MUL3: begin
                mx = ad_reg[31:0];
                my = (op_reg == OP_DIV) ? bm_reg[31:0] : bd_reg[31:0];
            end
            S_MUL4: begin mx = am_reg[31:0]; my = bm_reg[31:0]; end
            default: ;
        endcase
    end

    logic        bneg_eff;
    logic        comb_n;
    logic [MagW-1:0] comb_m;
    logic signed [MagW:0] lhs, rhs;
    always_comb begin
        bneg_eff = (op_reg == OP_SUB) ? !bn_reg : bn_reg;
        if (bm_reg == '0) bneg_eff = 1'b0;
        comb_n = an_reg;
        comb_m = p1_reg;
        if (op_reg == OP_ADD || op_reg == OP_SUB) begin
            if (an_reg == bneg_eff) begin
                comb_n = an_reg;
                comb_m = p1_reg + p2_reg;
            end else if (p1_reg >= p2_reg) begin
                comb_n = an_reg;
                comb_m = p1_reg - p2_reg;
            end else begin
                comb_n = bneg_eff;
                comb_m = p2_reg - p1_reg;
            end
            if (comb_m == '0) comb_n = 1'b0;
        end else begin
            comb_n = an_reg != bn_reg;
            if (op_reg == OP_MUL) comb_m = p4_reg;
        end
        lhs = an_reg ? -$signed({1'b0, p1_reg}) : $signed({1'b0, p1_reg});
        rhs = bn_reg ? -$signed({1'b0, p2_reg}) : $signed({1'b0, p2_reg});
    end

    logic [MagW-1:0] lim;
    logic            bad;
    assign lim = MagW'(1) << (Width - 1);
    always_comb begin
        bad = rn_reg ? (rm_reg > lim) : (rm_reg > lim - 1'b1);
        if (rd_reg > lim - 1'b1) bad = 1'b1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:        if (s_valid) state_next = S_NORM_A;
            S_NORM_A: begin
                if (am_reg == '0) state_next = S_NORM_B;
                else if (ad_reg == '0) state_next = S_OUT;
                else state_next = S_NORM_A_WAIT;
            end
            S_NORM_A_WAIT: if (grsp.done) state_next = S_DIV_AN;
            S_DIV_AN:      if (drsp.done) state_next = S_DIV_AD;
            S_DIV_AD:      if (drsp.done) state_next = S_NORM_B;
            S_NORM_B: begin
                if (bm_reg == '0) state_next = S_MUL1;
                else if (bd_reg == '0) state_next = S_OUT;
                else state_next = S_NORM_B_WAIT;
            end
            S_NORM_B_WAIT: if (grsp.done) state_next = S_DIV_BN;
            S_DIV_BN:      if (drsp.done) state_next = S_DIV_BD;
            S_DIV_BD:      if (drsp.done) state_next = S_MUL1;
            S_MUL1:        state_next = S_MUL2;
            S_MUL2:        state_next = S_MUL3;
            S_MUL3:        state_next = S_MUL4;
            S_MUL4:        state_next = S_COMBINE;
            S_COMBINE: begin
                if (op_reg == OP_DIV && bm_reg == '0) state_next = S_OUT;
                else state_next = S_RES_GCD;
            end
            S_RES_GCD: begin
                if (rm_reg == '0 || rd_reg == '0) state_next = S_CHECK;
                else state_next = S_RES_WAIT;
            end
            S_RES_WAIT:    if (grsp.done) state_next = S_DIV_RN;
            S_DIV_RN:      if (drsp.done) state_next = S_DIV_RD;
            S_DIV_RD:      if (drsp.done) state_next = S_CHECK;
            S_CHECK:       state_next = S_OUT;
            S_OUT:         if (m_ready) state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // unit commands
    always_comb begin
        gcmd = '0;
        dcmd = '0;
        unique case (state_reg)
            S_NORM_A: begin
                gcmd.start = (am_reg != '0) && (ad_reg != '0);
                gcmd.x = am_reg; gcmd.y = ad_reg;
            end
            S_NORM_B: begin
                gcmd.start = (bm_reg != '0) && (bd_reg != '0);
                gcmd.x = bm_reg; gcmd.y = bd_reg;
            end
            S_RES_GCD: begin
                gcmd.start = (rm_reg != '0) && (rd_reg != '0);
                gcmd.x = rm_reg; gcmd.y = rd_reg;
            end
            S_NORM_A_WAIT: begin dcmd.start = grsp.done; dcmd.n = am_reg; dcmd.d = grsp.g; end
            S_DIV_AN:      begin dcmd.start = drsp.done; dcmd.n = ad_reg; dcmd.d = g_reg; end
            S_NORM_B_WAIT: begin dcmd.start = grsp.done; dcmd.n = bm_reg; dcmd.d = grsp.g; end
            S_DIV_BN:      begin dcmd.start = drsp.done; dcmd.n = bd_reg; dcmd.d = g_reg; end
            S_RES_WAIT:    begin dcmd.start = grsp.done; dcmd.n = rm_reg; dcmd.d = grsp.g; end
            S_DIV_RN:      begin dcmd.start = drsp.done; dcmd.n = rd_reg; dcmd.d = g_reg; end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;

        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                op_reg     <= s_data.op;
                am_reg     <= mag_of(s_data.a_num);
                ad_reg     <= mag_of(s_data.a_den);
                an_reg     <= s_data.a_num[31] ^ s_data.a_den[31];
                bn_raw_reg <= s_data.b_num;
                bd_raw_reg <= s_data.b_den;
                status_reg <= ST_OK;
                less_reg   <= 1'b0;
                equal_reg  <= 1'b0;
            end
            S_NORM_A: begin
                bm_reg <= mag_of(bn_raw_reg);
                bd_reg <= mag_of(bd_raw_reg);
                bn_reg <= bn_raw_reg[31] ^ bd_raw_reg[31];
                if (am_reg == '0) begin
                    an_reg <= 1'b0;
                    ad_reg <= MagW'(1);
                end else if (ad_reg == '0) begin
                    status_reg <= ST_ZERO_DEN;
                end
            end
            S_NORM_A_WAIT: if (grsp.done) g_reg <= grsp.g;
            S_DIV_AN: if (drsp.done) am_reg <= drsp.q;
            S_DIV_AD: if (drsp.done) ad_reg <= drsp.q;
            S_NORM_B: begin
                if (bm_reg == '0) begin
                    bn_reg <= 1'b0;
                    bd_reg <= MagW'(1);
                end else if (bd_reg == '0) begin
                    status_reg <= ST_ZERO_DEN;
                end
            end
            S_NORM_B_WAIT: if (grsp.done) g_reg <= grsp.g;
            S_DIV_BN: if (drsp.done) bm_reg <= drsp.q;
            S_DIV_BD: if (drsp.done) bd_reg <= drsp.q;
            S_MUL1: p1_reg <= mprod;
            S_MUL2: p2_reg <= mprod;
            S_MUL3: p3_reg <= mprod;
            S_MUL4: p4_reg <= mprod;
            S_COMBINE: begin
                less_reg  <= lhs < rhs;
                equal_reg <= (an_reg == bn_reg) && (am_reg == bm_reg) && (ad_reg == bd_reg);
                rn_reg    <= comb_n;
                rm_reg    <= comb_m;
                rd_reg    <= p3_reg;
                if (op_reg == OP_DIV && bm_reg == '0) status_reg <= ST_DIV_ZERO;
            end
            S_RES_GCD: if (rm_reg == '0 || rd_reg == '0) begin
                rn_reg <= 1'b0;
                rm_reg <= '0;
                rd_reg <= MagW'(1);
            end
            S_RES_WAIT: if (grsp.done) g_reg <= grsp.g;
            S_DIV_RN: if (drsp.done) rm_reg <= drsp.q;
            S_DIV_RD: if (drsp.done) rd_reg <= drsp.q;
            S_CHECK: if (bad) status_reg <= ST_OVERFLOW;
            default: ;
        endcase

        // result register, loaded on the way into the output state
        if (state_next == S_OUT && state_reg != S_OUT) begin
            out_reg.a_less_b  <= (state_reg == S_CHECK || state_reg == S_COMBINE)
                                 ? ((state_reg == S_COMBINE) ? (lhs < rhs) : less_reg)
                                 : 1'b0;
            out_reg.a_equal_b <= (state_reg == S_CHECK) ? equal_reg
                                 : (state_reg == S_COMBINE)
                                 ? ((an_reg == bn_reg) && (am_reg == bm_reg) && (ad_reg == bd_reg))
                                 : 1'b0;
            if (state_reg == S_CHECK && !bad && status_reg == ST_OK) begin
                out_reg.res_num <= rn_reg ? (32'd0 - rm_reg[31:0]) : rm_reg[31:0];
                out_reg.res_den <= rd_reg[30:0];
                out_reg.status  <= ST_OK;
            end else begin
                out_reg.res_num <= '0;
                out_reg.res_den <= 31'd1;
                out_reg.status  <= (state_reg == S_CHECK) ? ST_OVERFLOW
                                 : (state_reg == S_COMBINE) ? ST_DIV_ZERO : ST_ZERO_DEN;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input and output both open");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.res_num == '0 && m_data.res_den == 31'd1))
        else $error("error result not zero over one");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_OK) |-> (m_data.res_den != '0))
        else $error("zero denominator delivered");

endmodule : rational_arithmetic_unit
`default_nettype wire
